/* hw/rtl/dwdiv_pkg.sv */
// Shared constants and types of the double-word by word divider.
`timescale 1ns / 1ps

package dwdiv_pkg;

	localparam int WORD_BITS = 32;
	localparam int STAGES    = WORD_BITS;
	localparam int STAT_BITS = 2;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic [STAT_BITS-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_DIV_ZERO = 2'd1,
		STATUS_OVERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		word_t   rem;
		word_t   lo;
		word_t   d;
		word_t   q;
		status_t status;
	} stage_t;

	typedef struct packed {
		status_t status;
		word_t   remainder;
		word_t   quotient;
	} result_t;

endpackage

/* hw/rtl/double_word_by_word_divider.sv */
// Pipelined unsigned divider of a double word by a single word.
`timescale 1ns / 1ps

// Usage: an input word on the s_axis channel carries dividend_high, dividend_low and
// divisor; the m_axis channel returns one result word per input word with the quotient,
// the remainder and a status code in tuser (0 ok, 1 divisor zero, 2 quotient overflow).
// On an error the quotient and remainder are zero.
// The divider is a restoring pipeline of one quotient bit per stage, 32 stages after an
// input register, so one word may be accepted in every cycle while the skid register is empty.
// A result passes through the input register, the stage registers and the output register to m_axis.
// Throughput: one word per cycle while the receiver keeps m_axis_tready high.
// The output register is backed by a skid register, so s_axis_tready is registered and
// does not depend on m_axis_tready. When the receiver stalls, one more result moves into
// the skid register and then the whole pipeline holds; nothing is lost or repeated.
// Reset (arst_n low, asynchronous) empties the pipeline and both output registers;
// s_axis_tready is high right after reset.
module double_word_by_word_divider (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// Fields from bit 0: dividend_high[31:0], dividend_low[63:32], divisor[95:64].
	input  logic [3*dwdiv_pkg::WORD_BITS-1:0]     s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// Fields from bit 0: quotient[31:0], remainder[63:32].
	output logic [2*dwdiv_pkg::WORD_BITS-1:0]     m_axis_tdata,
	// Fields from bit 0: status[1:0].
	output logic [dwdiv_pkg::STAT_BITS-1:0]       m_axis_tuser
);
	import dwdiv_pkg::*;

	stage_t  stg_s   [0:STAGES];
	logic    valid_s [0:STAGES];
	logic    en;
	word_t   in_hi;
	word_t   in_lo;
	word_t   in_d;
	status_t in_status;
	result_t end_res;
	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;
	logic    out_take;

	assign en            = !skid_valid_q;
	assign s_axis_tready = en;

	assign in_hi = s_axis_tdata[WORD_BITS-1:0];
	assign in_lo = s_axis_tdata[2*WORD_BITS-1:WORD_BITS];
	assign in_d  = s_axis_tdata[3*WORD_BITS-1:2*WORD_BITS];

	always_comb begin
		if (in_d == '0) begin
			in_status = STATUS_DIV_ZERO;
		end else if (in_hi >= in_d) begin
			in_status = STATUS_OVERFLOW;
		end else begin
			in_status = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stg_s[0].rem    <= in_hi;
			stg_s[0].lo     <= in_lo;
			stg_s[0].d      <= in_d;
			stg_s[0].q      <= '0;
			stg_s[0].status <= in_status;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_step
		logic [WORD_BITS:0] shifted;
		logic [WORD_BITS:0] diff;
		logic               take;

		assign shifted = {stg_s[i].rem, stg_s[i].lo[WORD_BITS-1]};
		assign diff    = shifted - {1'b0, stg_s[i].d};
		assign take    = shifted[WORD_BITS] || !diff[WORD_BITS];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else if (en) begin
				valid_s[i+1] <= valid_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stg_s[i+1].rem    <= take ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
				stg_s[i+1].lo     <= {stg_s[i].lo[WORD_BITS-2:0], 1'b0};
				stg_s[i+1].d      <= stg_s[i].d;
				stg_s[i+1].q      <= {stg_s[i].q[WORD_BITS-2:0], take};
				stg_s[i+1].status <= stg_s[i].status;
			end
		end
	end

	always_comb begin
		end_res.status = stg_s[STAGES].status;
		if (stg_s[STAGES].status == STATUS_OK) begin
			end_res.quotient  = stg_s[STAGES].q;
			end_res.remainder = stg_s[STAGES].rem;
		end else begin
			end_res.quotient  = '0;
			end_res.remainder = '0;
		end
	end

	assign out_take = out_valid_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (valid_s[STAGES]) begin
			if (!out_valid_q || out_take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (valid_s[STAGES]) begin
			if (!out_valid_q || out_take) begin
				out_q <= end_res;
			end else begin
				skid_q <= end_res;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.remainder, out_q.quotient};
	assign m_axis_tuser  = out_q.status;

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("Skid register holds a word while the output register is empty.");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !m_axis_tready |=> skid_valid_q && $stable(skid_q))
		else $error("Skid register changed while the output was stalled.");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != STATUS_OK |-> out_q.quotient == '0
			&& out_q.remainder == '0)
		else $error("Error result carries a nonzero quotient or remainder.");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[STAGES] && stg_s[STAGES].status == STATUS_OK
			|-> stg_s[STAGES].rem < stg_s[STAGES].d)
		else $error("Final remainder is not below the divisor.");
`endif

endmodule

/* dv/tb_double_word_by_word_divider.sv */
// Self-checking testbench of the double-word by word divider, directed table then random words.
`timescale 1ns / 1ps

module tb_double_word_by_word_divider;

	import dwdiv_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int DIRECTED_ROWS = 19;

	typedef struct packed {
		word_t   hi;
		word_t   lo;
		word_t   d;
		logic    fixed;
		word_t   q;
		word_t   r;
		status_t st;
	} div_case_t;

	// Rows with fixed set carry their answer; the others go through the predictor.
	localparam div_case_t DIRECTED [DIRECTED_ROWS] = '{
		'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0, 32'h0, STATUS_DIV_ZERO},
		'{32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000, 1'b1, 32'h0, 32'h0, STATUS_DIV_ZERO},
		'{32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0, 32'h0, STATUS_OK},
		'{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 1'b1, 32'hffff_ffff, 32'h0, STATUS_OK},
		'{32'h0000_0001, 32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0, 32'h0, STATUS_OVERFLOW},
		'{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'h0, 32'h0, STATUS_OVERFLOW},
		'{32'hffff_fffe, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'hffff_ffff, 32'hffff_fffe,
			STATUS_OK},
		'{32'h0000_0001, 32'h0000_0000, 32'h0000_0002, 1'b1, 32'h8000_0000, 32'h0, STATUS_OK},
		'{32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'h1, 32'h0, STATUS_OK},
		'{32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000, 1'b1, 32'hffff_ffff, 32'h7fff_ffff,
			STATUS_OK},
		'{32'h0000_0000, 32'h0000_0000, 32'hffff_ffff, 1'b1, 32'h0, 32'h0, STATUS_OK},
		'{32'h0000_ffff, 32'h0000_0000, 32'h0000_ffff, 1'b1, 32'h0, 32'h0, STATUS_OVERFLOW},
		'{32'h0000_0000, 32'h0000_0005, 32'h0000_0002, 1'b0, 32'h0, 32'h0, STATUS_OK},
		'{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 1'b0, 32'h0, 32'h0, STATUS_OK},
		'{32'h1234_5678, 32'h9abc_def0, 32'h8765_4321, 1'b0, 32'h0, 32'h0, STATUS_OK},
		'{32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 1'b0, 32'h0, 32'h0, STATUS_OK},
		'{32'h0000_fffe, 32'hffff_ffff, 32'h0000_ffff, 1'b0, 32'h0, 32'h0, STATUS_OK},
		'{32'h8000_0000, 32'h0000_0000, 32'h8000_0001, 1'b0, 32'h0, 32'h0, STATUS_OK},
		'{32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaab, 1'b0, 32'h0, 32'h0, STATUS_OK}
	};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [3*WORD_BITS-1:0]   s_axis_tdata = '0;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [2*WORD_BITS-1:0]   m_axis_tdata;
	logic [STAT_BITS-1:0]     m_axis_tuser;

	div_case_t operand_words[$];
	result_t   pending_results[$];
	div_case_t word_in_flight;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	int        quiet_cycles = 0;
	int        error_count = 0;

	double_word_by_word_divider u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic result_t divide_dword(word_t hi, word_t lo, word_t d);
		result_t                res;
		logic [2*WORD_BITS-1:0] dividend;
		res = '0;
		dividend = {hi, lo};
		if (d == '0) begin
			res.status = STATUS_DIV_ZERO;
		end else if (hi >= d) begin
			res.status = STATUS_OVERFLOW;
		end else begin
			res.status    = STATUS_OK;
			res.quotient  = word_t'(dividend / d);
			res.remainder = word_t'(dividend % d);
		end
		return res;
	endfunction

	// Mostly legal divisions over a spread of divisor sizes, with some error cases mixed in.
	function automatic div_case_t random_division();
		div_case_t c;
		word_t     a;
		word_t     b;
		int        kind;
		c = '0;
		kind = $urandom_range(99);
		c.lo = $urandom;
		if ($urandom_range(15) == 0)
			c.lo = ($urandom_range(1) != 0) ? '1 : '0;
		if (kind < 6) begin
			c.hi = $urandom;
			c.d  = '0;
		end else if (kind < 14) begin
			a = $urandom;
			b = $urandom;
			if (b == '0)
				b = 1;
			c.hi = (a >= b) ? a : b;
			c.d  = (a >= b) ? b : a;
			if (c.d == '0)
				c.d = 1;
			if ($urandom_range(3) == 0)
				c.hi = c.d;
		end else begin
			if (kind < 30)
				c.d = $urandom_range(255, 1);
			else if (kind < 50)
				c.d = $urandom | 32'h8000_0000;
			else
				c.d = $urandom >> $urandom_range(31, 0);
			if (c.d == '0)
				c.d = 1;
			c.hi = (kind % 9 == 0) ? c.d - 1 : $urandom % c.d;
		end
		return c;
	endfunction

	// Sender: holds a word until it is taken, then offers the next one or idles.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (word_in_flight.fixed)
					pending_results.push_back('{word_in_flight.st, word_in_flight.r,
						word_in_flight.q});
				else
					pending_results.push_back(divide_dword(word_in_flight.hi,
						word_in_flight.lo, word_in_flight.d));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (operand_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					word_in_flight = operand_words.pop_front();
					s_axis_tdata  <= {word_in_flight.d, word_in_flight.lo, word_in_flight.hi};
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks every result word against the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_results.size() == 0) begin
					$error("result word with no expected result: tdata %h tuser %h",
						m_axis_tdata, m_axis_tuser);
					error_count++;
				end else begin
					want = pending_results.pop_front();
					if (m_axis_tdata[WORD_BITS-1:0] !== want.quotient) begin
						$error("quotient: expected %h, actual %h", want.quotient,
							m_axis_tdata[WORD_BITS-1:0]);
						error_count++;
					end
					if (m_axis_tdata[2*WORD_BITS-1:WORD_BITS] !== want.remainder) begin
						$error("remainder: expected %h, actual %h", want.remainder,
							m_axis_tdata[2*WORD_BITS-1:WORD_BITS]);
						error_count++;
					end
					if (m_axis_tuser !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
						error_count++;
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			quiet_cycles <= ((s_axis_tvalid && s_axis_tready) ||
				(m_axis_tvalid && m_axis_tready)) ? 0 : quiet_cycles + 1;
	end

	initial begin : watchdog
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("TEST FAILED");
		$finish;
	end

	initial begin : run
		int phase;
		int n;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 23;
					recv_idle_pct = 62;
					for (n = 0; n < DIRECTED_ROWS; n++)
						operand_words.push_back(DIRECTED[n]);
				end
				1: begin
					send_idle_pct = 62;
					recv_idle_pct = 23;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (n = 0; n < 267; n++)
				operand_words.push_back(random_division());
			while (operand_words.size() > 0 || s_axis_tvalid || pending_results.size() > 0)
				@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
